/* rtl/tpsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder package
// Shared widths, defaults, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int unsigned DEF_MAX_WIDTH_LOG2  = 12;
  localparam int unsigned DEF_MAX_HEIGHT_LOG2 = 12;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned PARTIAL_W  = 24;
  localparam int unsigned FULL_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [2:0]        BPP_MIN        = 3'd2;
  localparam logic [2:0]        BPP_MAX        = 3'd4;
  localparam logic [2:0]        BPP_RESET      = 3'd4;
  localparam logic              RUN_RESET      = 1'b1;
  localparam logic [3:0]        WLOG_RESET     = 4'd8;
  localparam logic [3:0]        HLOG_RESET     = 4'd8;
  localparam logic [3:0]        WLOG_MIN       = 4'd2;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'd255;
  localparam int unsigned       HDR_REPEAT_BIT = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_RUN_CODED       = 2'd1,
    CFG_WIDTH_LOG2      = 2'd2,
    CFG_HEIGHT_LOG2     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic run_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pix_complete;
    logic slot_free;
    logic run_end;
  } dp_status_t;

endpackage

/* rtl/tpsd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder channels
// Byte input, segment output and configuration write channels.
// ----------------------------------------------------------------------------
interface tpsd_byte_if
  import tpsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tpsd_seg_if
  import tpsd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;
  logic [BYTE_W-1:0]  alpha;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] dest_row;
  logic [RUN_W-1:0]   repeat_length;
  logic               image_done;
  logic               last;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output column, output dest_row, output repeat_length, output image_done,
    output last, input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input column, input dest_row, input repeat_length, input image_done,
    input last, output ready
  );
endinterface

interface tpsd_cfg_if
  import tpsd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tpsd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder controller
// Takes bytes while idle and steps the segment generator through a pixel run.
// ----------------------------------------------------------------------------
module tpsd_ctrl
  import tpsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.pix_complete) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.run_step = status_i.slot_free;
        if (status_i.slot_free && status_i.run_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/tpsd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder datapath
// Configuration registers, packet and pixel assembly, image position and the
// segment generator with its output register.
// ----------------------------------------------------------------------------
module tpsd_datapath
  import tpsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH_LOG2  = DEF_MAX_WIDTH_LOG2,
  parameter int unsigned MAX_HEIGHT_LOG2 = DEF_MAX_HEIGHT_LOG2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_byte_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  tpsd_cfg_if.sink          cfg_i,
  tpsd_seg_if.source        seg_o
);

  localparam int unsigned CW  = MAX_WIDTH_LOG2;
  localparam int unsigned WW  = CW + 1;
  localparam int unsigned RW  = MAX_HEIGHT_LOG2 + 1;
  localparam int unsigned CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int unsigned RXW = (RW > COORD_W) ? RW : COORD_W;
  localparam int unsigned SXW = (WW > RUN_W) ? WW : RUN_W;
  localparam logic [3:0]  WLOG_MAX = 4'(MAX_WIDTH_LOG2);
  localparam logic [3:0]  HLOG_MAX = 4'(MAX_HEIGHT_LOG2);

  logic [2:0] bpp_cfg_q;
  logic       run_coded_q;
  logic [3:0] wlog_q;
  logic [3:0] hlog_q;

  logic                 eh_q, eh_d;
  logic                 rep_q, rep_d;
  logic [RUN_W-1:0]     left_q, left_d;
  logic [1:0]           bip_q, bip_d;
  logic [PARTIAL_W-1:0] part_q, part_d;
  logic [CW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic                 fin_q, fin_d;
  logic [RUN_W-1:0]     count_q, count_d;
  logic [BYTE_W-1:0]    pr_q, pr_d, pg_q, pg_d, pb_q, pb_d, pa_q, pa_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 pix_complete;
  logic [BYTE_W-1:0]    red_q, green_q, blue_q, alpha_q;
  logic [COORD_W-1:0]   column_q, dest_row_q;
  logic [RUN_W-1:0]     len_q;
  logic                 done_q, last_q;

  logic [2:0]           bpp;
  logic [3:0]           wl, hl;
  logic [WW-1:0]        w;
  logic [RW-1:0]        h;
  logic [FULL_W-1:0]    full;
  logic [15:0]          c16;
  logic [RUN_W-1:0]     cnt;

  logic                 col_wrap;
  logic [CW-1:0]        col_eff;
  logic [RW-1:0]        row_eff;
  logic                 row_ovf;
  logic [WW-1:0]        rem;
  logic [RUN_W-1:0]     seg;
  logic [WW-1:0]        col_new;
  logic                 col_new_wrap;
  logic [RW-1:0]        row_after;
  logic                 seg_done;
  logic [RUN_W-1:0]     count_left;
  logic [RW-1:0]        dest_full;
  logic [RXW-1:0]       dest_ext;
  logic [CXW-1:0]       col_ext;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_cfg_q   <= BPP_RESET;
      run_coded_q <= RUN_RESET;
      wlog_q      <= WLOG_RESET;
      hlog_q      <= HLOG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_BYTES_PER_PIXEL: bpp_cfg_q   <= cfg_i.data[2:0];
        CFG_RUN_CODED:       run_coded_q <= cfg_i.data[0];
        CFG_WIDTH_LOG2:      wlog_q      <= cfg_i.data;
        CFG_HEIGHT_LOG2:     hlog_q      <= cfg_i.data;
      endcase
    end
  end

  always_comb begin
    if (bpp_cfg_q < BPP_MIN) begin
      bpp = BPP_MIN;
    end else if (bpp_cfg_q > BPP_MAX) begin
      bpp = BPP_MAX;
    end else begin
      bpp = bpp_cfg_q;
    end
    if (wlog_q < WLOG_MIN) begin
      wl = WLOG_MIN;
    end else if (wlog_q > WLOG_MAX) begin
      wl = WLOG_MAX;
    end else begin
      wl = wlog_q;
    end
    hl = (hlog_q > HLOG_MAX) ? HLOG_MAX : hlog_q;
  end

  assign w = WW'(1) << wl;
  assign h = RW'(1) << hl;

  // Segment generator: one row segment of the pending run per step.
  assign col_wrap     = {1'b0, col_q} >= w;
  assign col_eff      = col_wrap ? '0 : col_q;
  assign row_eff      = col_wrap ? row_q + RW'(1) : row_q;
  assign row_ovf      = row_eff >= h;
  assign rem          = w - {1'b0, col_eff};
  assign seg          = (SXW'(rem) < SXW'(count_q)) ? RUN_W'(rem) : count_q;
  assign col_new      = {1'b0, col_eff} + WW'(seg);
  assign col_new_wrap = col_new >= w;
  assign row_after    = row_eff + RW'(1);
  assign seg_done     = col_new_wrap && (row_after >= h);
  assign count_left   = count_q - seg;
  assign dest_full    = h - row_eff - RW'(1);
  assign dest_ext     = RXW'(dest_full);
  assign col_ext      = CXW'(col_eff);

  assign status_o.slot_free    = !out_valid_q || seg_o.ready;
  assign status_o.run_end      = row_ovf || seg_done || (count_left == '0);
  assign status_o.pix_complete = pix_complete;

  always_comb begin
    eh_d     = eh_q;
    rep_d    = rep_q;
    left_d   = left_q;
    bip_d    = bip_q;
    part_d   = part_q;
    col_d    = col_q;
    row_d    = row_q;
    fin_d    = fin_q;
    count_d  = count_q;
    pr_d     = pr_q;
    pg_d     = pg_q;
    pb_d     = pb_q;
    pa_d     = pa_q;
    full     = '0;
    c16      = '0;
    cnt      = RUN_W'(1);
    out_load = 1'b0;
    pix_complete = 1'b0;

    if (cmd_i.accept) begin
      if (first_byte_i) begin
        eh_d   = 1'b1;
        rep_d  = 1'b0;
        left_d = '0;
        bip_d  = '0;
        part_d = '0;
        col_d  = '0;
        row_d  = '0;
        fin_d  = 1'b0;
      end
      if (!fin_d) begin
        if (run_coded_q && eh_d) begin
          left_d = {1'b0, data_byte_i[6:0]} + RUN_W'(1);
          rep_d  = data_byte_i[HDR_REPEAT_BIT];
          eh_d   = 1'b0;
        end else if (({1'b0, bip_d} + 3'd1) < bpp) begin
          part_d = part_d | PARTIAL_W'(FULL_W'(data_byte_i) << {bip_d, 3'b000});
          bip_d  = bip_d + 2'd1;
        end else begin
          full   = {8'b0, part_d} | (FULL_W'(data_byte_i) << {bip_d, 3'b000});
          bip_d  = '0;
          part_d = '0;
          if (bpp == BPP_MIN) begin
            c16  = full[15:0];
            pr_d = {c16[14:10], 3'b000};
            pg_d = {c16[9:5], 3'b000};
            pb_d = {c16[4:0], 3'b000};
            pa_d = ALPHA_OPAQUE;
          end else begin
            pb_d = full[7:0];
            pg_d = full[15:8];
            pr_d = full[23:16];
            pa_d = (bpp == BPP_MAX) ? full[31:24] : ALPHA_OPAQUE;
          end
          if (run_coded_q) begin
            if (rep_d) begin
              cnt    = left_d;
              left_d = '0;
            end else if (left_d != '0) begin
              left_d = left_d - RUN_W'(1);
            end
            if (cnt == '0) begin
              cnt = RUN_W'(1);
            end
            if (left_d == '0) begin
              eh_d = 1'b1;
            end
          end
          count_d = cnt;
          pix_complete = 1'b1;
        end
      end
    end else if (cmd_i.run_step) begin
      if (row_ovf) begin
        col_d = col_eff;
        row_d = row_eff;
        fin_d = 1'b1;
      end else begin
        out_load = 1'b1;
        count_d  = count_left;
        if (col_new_wrap) begin
          col_d = '0;
          row_d = row_after;
          fin_d = seg_done;
        end else begin
          col_d = CW'(col_new);
          row_d = row_eff;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !seg_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eh_q        <= 1'b1;
      rep_q       <= 1'b0;
      left_q      <= '0;
      bip_q       <= '0;
      part_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      fin_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      eh_q        <= eh_d;
      rep_q       <= rep_d;
      left_q      <= left_d;
      bip_q       <= bip_d;
      part_q      <= part_d;
      col_q       <= col_d;
      row_q       <= row_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q <= pr_d;
    pg_q <= pg_d;
    pb_q <= pb_d;
    pa_q <= pa_d;
    if (out_load) begin
      red_q      <= pr_q;
      green_q    <= pg_q;
      blue_q     <= pb_q;
      alpha_q    <= pa_q;
      column_q   <= col_ext[COORD_W-1:0];
      dest_row_q <= dest_ext[COORD_W-1:0];
      len_q      <= seg;
      done_q     <= seg_done;
      last_q     <= seg_done || (count_left == '0);
    end
  end

  assign seg_o.valid         = out_valid_q;
  assign seg_o.red           = red_q;
  assign seg_o.green         = green_q;
  assign seg_o.blue          = blue_q;
  assign seg_o.alpha         = alpha_q;
  assign seg_o.column        = column_q;
  assign seg_o.dest_row      = dest_row_q;
  assign seg_o.repeat_length = len_q;
  assign seg_o.image_done    = done_q;
  assign seg_o.last          = last_q;

endmodule

/* rtl/tga_pixel_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder
// Decodes raw or run-length coded TGA pixel bytes into RGBA row segments.
// ----------------------------------------------------------------------------
// Header bytes and bytes that do not complete a pixel are taken one per cycle
// while no run is being emitted. A byte that completes a pixel starts a run of
// row segments: one segment for a pixel inside a row, up to 33 for a repeat
// run of 128 crossing rows of width 4. The single segment generator emits them
// in turn, held by a stalled output register; no byte is taken meanwhile. A
// run that starts past the last row of the image gives no item.
module tga_pixel_stream_decoder
  import tpsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH_LOG2  = DEF_MAX_WIDTH_LOG2,
  parameter int unsigned MAX_HEIGHT_LOG2 = DEF_MAX_HEIGHT_LOG2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpsd_byte_if.sink  byte_i,
  tpsd_cfg_if.sink   cfg_i,
  tpsd_seg_if.source seg_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign byte_i.ready = in_ready;

  tpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpsd_datapath #(
    .MAX_WIDTH_LOG2  (MAX_WIDTH_LOG2),
    .MAX_HEIGHT_LOG2 (MAX_HEIGHT_LOG2)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (byte_i.data_byte),
    .first_byte_i (byte_i.first_byte),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg_i),
    .seg_o        (seg_o)
  );

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> seg_o.repeat_length != '0)
    else $error("segment with zero length");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && seg_o.image_done |-> seg_o.last)
    else $error("image end segment not marked last");

  a_no_take_mid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && !seg_o.last |-> !byte_i.ready)
    else $error("byte taken while a run is still being emitted");

  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.run_step))
    else $error("accept and run step issued together");

endmodule
